// File: rtl/core/srcs_pkg.sv
// Shared types and constants for the sixteen-bit core step block.
package srcs_pkg;

  localparam int unsigned StatusReg = 17;
  localparam int unsigned LinkReg   = 18;

  typedef enum logic [1:0] {
    FUNC_MEM_WR  = 2'd0,
    FUNC_REG_WR  = 2'd1,
    FUNC_EXEC    = 2'd2,
    FUNC_SET_PC  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_MEMF    = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_END     = 3'd3,
    ST_DIVZ    = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_AND  = 5'd4,  OP_OR   = 5'd5,  OP_XOR  = 5'd6,  OP_NOR  = 5'd7,
    OP_SLT  = 5'd8,  OP_SLL  = 5'd9,  OP_SRA  = 5'd10, OP_SRL  = 5'd11,
    OP_JR   = 5'd12, OP_PRT  = 5'd13, OP_ADDI = 5'd14, OP_LD   = 5'd15,
    OP_ST   = 5'd16, OP_ANDI = 5'd17, OP_ORI  = 5'd18, OP_BEQ  = 5'd19,
    OP_BNE  = 5'd20, OP_J    = 5'd21, OP_JAL  = 5'd22
  } op_e;

  // request to the divider
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/srcs_ram.sv
// Generic single-port RAM with registered read.
module srcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/core/srcs_div.sv
// Signed 16-bit restoring divider, one quotient bit per cycle.
module srcs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srcs_pkg::div_req_t  req_i,
  output srcs_pkg::div_rsp_t  rsp_o
);
  import srcs_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q, quo_q, dvs_q;
  logic        neg_q;
  logic [16:0] trial;
  logic [15:0] abs_a, abs_b;

  assign abs_a = req_i.dividend[15] ? 16'(-req_i.dividend) : req_i.dividend;
  assign abs_b = req_i.divisor[15] ? 16'(-req_i.divisor) : req_i.divisor;
  assign trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= abs_a;
      dvs_q <= abs_b;
      neg_q <= req_i.dividend[15] ^ req_i.divisor[15];
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[14:0], quo_q[15]};
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

  // quotient is final the cycle after the last step
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? 16'(-quo_q) : quo_q;

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 5'd0) else $error("divider count underflow");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == 5'd16) else $error("divider did not start");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd1) |=> !busy_q) else $error("divider overran");
`endif
endmodule

// File: rtl/core/sixteen_bit_risc_core_step_top.sv
// Top level of the sixteen-bit core step block.
//
// channel   dir  handshake            payload
// cmd       in   start & !busy        func_i, target_i, value_i
// result    out  done_o (one cycle)   status_o, halted_o, print_valid_o, print_value_o, next_pc_o
// cfg       in   APB write            code_base (0x0), stack_base (0x4)
//
// Writes, set-pc and execute while halted or with pc past memory go from accept
// straight to the result beat; execute steps through fetch read, decode/register
// read, execute and result beat, a load adds a memory state that waits for read
// data, and divide waits in the divider. Busy stays high through the result beat;
// the receiver cannot stall. Reset is asynchronous and clears pc, config, register
// file; memory is not cleared.
module sixteen_bit_risc_core_step_top #(
  parameter int unsigned MEMORY_WORDS   = 4096,
  parameter int unsigned REGISTER_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] target_i,
  input  logic [31:0] value_i,
  output logic [2:0]  status_o,
  output logic        halted_o,
  output logic        print_valid_o,
  output logic signed [15:0] print_value_o,
  output logic [15:0] next_pc_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srcs_pkg::*;

  localparam int unsigned AW = $clog2(MEMORY_WORDS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_MEM   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] code_base_q, stack_base_q, pc_q;
  logic [15:0] rf_q [REGISTER_COUNT];
  logic [31:0] value_q;
  logic [31:0] ir_q;
  logic [15:0] a_q, b_q, c_q;
  logic        pv_q;
  logic [15:0] pval_q;

  // config port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      1'b0:    prdata = {16'd0, code_base_q};
      default: prdata = {16'd0, stack_base_q};
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_base_q  <= '0;
      stack_base_q <= '0;
    end else if (cfg_we && paddr[1:0] == 2'd0) begin
      if (paddr[2]) stack_base_q <= pwdata[15:0];
      else          code_base_q  <= pwdata[15:0];
    end
  end

  // decoded instruction fields
  logic [4:0]  op, rr, rs, rt;
  logic [15:0] imm;
  assign op  = ir_q[31:27];
  assign rr  = ir_q[26:22];
  assign rs  = ir_q[21:17];
  assign rt  = ir_q[16:12];
  assign imm = (op == OP_J || op == OP_JAL) ? ir_q[26:11] : ir_q[16:1];

  function automatic logic [15:0] rd_reg(input logic [15:0] idx,
                                         input logic [15:0] rf [REGISTER_COUNT]);
    logic [15:0] v;
    v = '0;
    if (idx < 16'(REGISTER_COUNT)) v = rf[idx[$clog2(REGISTER_COUNT)-1:0]];
    return v;
  endfunction

  logic [15:0] status_reg;
  assign status_reg = rf_q[StatusReg];

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  srcs_ram #(.Width(32), .Depth(MEMORY_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_seen_q;
  srcs_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // address of load/store, signed 17 bit
  logic signed [16:0] ls_addr;
  logic               ls_bad;
  assign ls_addr = 17'(signed'(a_q)) + 17'(signed'(imm));
  assign ls_bad  = (ls_addr < $signed({1'b0, stack_base_q})) ||
                   ($signed({ls_addr[16], ls_addr}) >= $signed(18'(MEMORY_WORDS)));

  // single ALU, used in EXEC
  logic [15:0] alu;
  logic [31:0] prod;
  assign prod = 32'(a_q) * 32'(b_q);
  always_comb begin
    alu = '0;
    unique case (op)
      OP_ADD:  alu = a_q + b_q;
      OP_SUB:  alu = a_q - b_q;
      OP_MUL:  alu = prod[15:0];
      OP_AND:  alu = a_q & b_q;
      OP_OR:   alu = a_q | b_q;
      OP_XOR:  alu = a_q ^ b_q;
      OP_NOR:  alu = ~(a_q | b_q);
      OP_SLT:  alu = {15'd0, $signed(a_q) < $signed(b_q)};
      OP_SLL:  alu = (b_q >= 16'd16) ? 16'd0 : a_q << b_q[3:0];
      OP_SRA:  alu = (b_q >= 16'd16) ? {16{a_q[15]}} : 16'($signed(a_q) >>> b_q[3:0]);
      OP_SRL:  alu = (b_q >= 16'd16) ? 16'd0 : a_q >> b_q[3:0];
      OP_ADDI: alu = a_q + imm;
      OP_ANDI: alu = a_q & imm;
      OP_ORI:  alu = a_q | imm;
      default: alu = '0;
    endcase
  end

  logic        rf_we;
  logic [15:0] rf_widx, rf_wdata;
  logic [15:0] pc_d;
  logic        pv_d;
  logic [15:0] pval_d;

  always_comb begin
    state_d   = state_q;
    rf_we     = 1'b0;
    rf_widx   = 16'(rr);
    rf_wdata  = alu;
    pc_d      = pc_q;
    pv_d      = pv_q;
    pval_d    = pval_q;
    mem_we    = 1'b0;
    mem_addr  = pc_q[AW-1:0];
    mem_wdata = value_q;
    div_req   = '{start: 1'b0, dividend: a_q, divisor: b_q};
    unique case (state_q)
      S_IDLE: begin
        mem_addr = target_i[AW-1:0];
        if (start) begin
          pv_d   = 1'b0;
          pval_d = '0;
          priority case (func_i)
            FUNC_MEM_WR: begin
              mem_we    = {1'b0, target_i} < 17'(MEMORY_WORDS);
              mem_wdata = value_i;
              state_d   = S_DONE;
            end
            FUNC_REG_WR: begin
              rf_we    = 1'b1;
              rf_widx  = target_i;
              rf_wdata = value_i[15:0];
              state_d  = S_DONE;
            end
            FUNC_SET_PC: begin
              pc_d    = value_i[15:0];
              state_d = S_DONE;
            end
            default: begin
              if (status_reg != 16'd0) begin
                state_d = S_DONE;
              end else if ({1'b0, pc_q} >= 17'(MEMORY_WORDS)) begin
                rf_we = 1'b1; rf_widx = 16'(StatusReg); rf_wdata = 16'(ST_MEMF);
                state_d = S_DONE;
              end else begin
                mem_addr = pc_q[AW-1:0];
                state_d  = S_FETCH;
              end
            end
          endcase
        end
      end
      S_FETCH: state_d = S_DEC;
      S_DEC:   state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        pc_d    = pc_q + 16'd1;
        if (ir_q == 32'd0) begin
          rf_we = 1'b1; rf_widx = 16'(StatusReg); rf_wdata = 16'(ST_END);
          pc_d  = pc_q;
        end else if (op > OP_JAL) begin
          rf_we = 1'b1; rf_widx = 16'(StatusReg); rf_wdata = 16'(ST_ILLEGAL);
        end else begin
          unique case (op)
            OP_DIV: begin
              pc_d = pc_q;
              if (b_q == 16'd0) begin
                rf_we = 1'b1; rf_widx = 16'(StatusReg); rf_wdata = 16'(ST_DIVZ);
                pc_d  = pc_q + 16'd1;
              end else begin
                div_req.start = 1'b1;
                state_d = S_DIV;
              end
            end
            OP_JR:  pc_d = c_q + 16'd1;
            OP_PRT: begin pv_d = 1'b1; pval_d = c_q; end
            OP_LD, OP_ST: begin
              mem_addr = ls_addr[AW-1:0];
              if (ls_bad) begin
                rf_we = 1'b1; rf_widx = 16'(StatusReg); rf_wdata = 16'(ST_MEMF);
              end else if (op == OP_ST) begin
                mem_we    = 1'b1;
                mem_wdata = {{16{c_q[15]}}, c_q};
              end else begin
                pc_d    = pc_q;
                state_d = S_MEM;
              end
            end
            OP_BEQ: if (c_q == a_q) pc_d = imm + code_base_q;
            OP_BNE: if (c_q != a_q) pc_d = imm + code_base_q;
            OP_J:   pc_d = imm + code_base_q;
            OP_JAL: begin
              rf_we = 1'b1; rf_widx = 16'(LinkReg); rf_wdata = pc_q;
              pc_d  = imm + 16'd1;
            end
            default: rf_we = 1'b1;
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done && div_seen_q) begin
          rf_we    = 1'b1;
          rf_wdata = div_rsp.quotient;
          pc_d     = pc_q + 16'd1;
          state_d  = S_DONE;
        end
      end
      S_MEM: begin
        mem_addr = ls_addr[AW-1:0];
        if (div_seen_q) begin
          rf_we    = 1'b1;
          rf_wdata = mem_rdata[15:0];
          pc_d     = pc_q + 16'd1;
          state_d  = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pc_q       <= '0;
      pv_q       <= 1'b0;
      pval_q     <= '0;
      div_seen_q <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) rf_q[i] <= '0;
    end else begin
      state_q    <= state_d;
      pc_q       <= pc_d;
      pv_q       <= pv_d;
      pval_q     <= pval_d;
      // wait in MEM for read data; in DIV until divider finishes
      div_seen_q <= (state_q == S_MEM || state_q == S_DIV) && state_d == state_q;
      if (rf_we && rf_widx < 16'(REGISTER_COUNT)) begin
        rf_q[rf_widx[$clog2(REGISTER_COUNT)-1:0]] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      value_q  <= value_i;
    end
    if (state_q == S_FETCH) ir_q <= mem_rdata;
    if (state_q == S_DEC) begin
      a_q <= rd_reg(16'(rs), rf_q);
      b_q <= rd_reg(16'(rt), rf_q);
      c_q <= rd_reg(16'(rr), rf_q);
    end
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = state_q == S_DONE;
  assign status_o      = status_reg[2:0];
  assign halted_o      = status_reg != 16'd0;
  assign print_valid_o = pv_q;
  assign print_value_o = pval_q;
  assign next_pc_o     = pc_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command not busy");
  a_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !print_valid_o |-> print_value_o == 16'sd0) else $error("stray print value");
`endif
endmodule

// File: dv/sixteen_bit_risc_core_step_top_tb.sv
// Self-checking testbench for the sixteen-bit core step block.
module sixteen_bit_risc_core_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srcs_pkg::*;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned RegCount = 32;
  localparam logic [2:0] AddrCodeBase  = 3'd0;
  localparam logic [2:0] AddrStackBase = 3'd4;

  typedef struct {
    logic [2:0]  status;
    logic        halted;
    logic        print_valid;
    logic [15:0] print_value;
    logic [15:0] next_pc;
  } core_result_t;

  logic        clk_i, rst_ni;
  logic        start, busy, done_o;
  logic [1:0]  func_i;
  logic [15:0] target_i;
  logic [31:0] value_i;
  logic [2:0]  status_o;
  logic        halted_o, print_valid_o;
  logic signed [15:0] print_value_o;
  logic [15:0] next_pc_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  sixteen_bit_risc_core_step_top u_top (.*);

  // core state as the testbench sees it
  logic [15:0] pc_q;
  logic [15:0] regs_q [RegCount];
  logic [31:0] mem_q [MemWords];
  bit          mem_set [MemWords];
  logic [15:0] code_base_q, stack_base_q;

  core_result_t pending_results[$];
  int mismatches;
  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int sx16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int mem_addr(logic [31:0] w);
    return sx16(regs_q[w[21:17]]) + sx16(w[16:1]);
  endfunction

  function automatic bit addr_ok(int a);
    return a >= int'(stack_base_q) && a < MemWords;
  endfunction

  task automatic run_instr(output logic pv, output logic [15:0] pval);
    logic [31:0] w;
    op_e op;
    logic [4:0] rr, rs, rt;
    logic [15:0] a, b, imm;
    int q, addr;
    pv = 1'b0;
    pval = '0;
    if (pc_q >= MemWords) begin
      regs_q[StatusReg] = 16'(ST_MEMF);
      return;
    end
    w = mem_q[pc_q];
    if (w == 0) begin
      regs_q[StatusReg] = 16'(ST_END);
      return;
    end
    op = op_e'(w[31:27]);
    rr = w[26:22];
    rs = w[21:17];
    rt = w[16:12];
    imm = (op == OP_J || op == OP_JAL) ? w[26:11] : w[16:1];
    a = regs_q[rs];
    b = regs_q[rt];
    if (w[31:27] > OP_JAL) regs_q[StatusReg] = 16'(ST_ILLEGAL);
    else case (op)
      OP_ADD: regs_q[rr] = a + b;
      OP_SUB: regs_q[rr] = a - b;
      OP_MUL: regs_q[rr] = a * b;
      OP_DIV: begin
        if (b == 0) regs_q[StatusReg] = 16'(ST_DIVZ);
        else begin
          q = sx16(a) / sx16(b);
          regs_q[rr] = q[15:0];
        end
      end
      OP_AND: regs_q[rr] = a & b;
      OP_OR:  regs_q[rr] = a | b;
      OP_XOR: regs_q[rr] = a ^ b;
      OP_NOR: regs_q[rr] = ~(a | b);
      OP_SLT: regs_q[rr] = (sx16(a) < sx16(b)) ? 16'd1 : 16'd0;
      OP_SLL: regs_q[rr] = (b >= 16) ? 16'd0 : 16'(a << b);
      OP_SRA: regs_q[rr] = $signed(a) >>> ((b > 15) ? 15 : b);
      OP_SRL: regs_q[rr] = (b >= 16) ? 16'd0 : a >> b;
      OP_JR:  pc_q = regs_q[rr];
      OP_PRT: begin
        pv = 1'b1;
        pval = regs_q[rr];
      end
      OP_ADDI: regs_q[rr] = a + imm;
      OP_ANDI: regs_q[rr] = a & imm;
      OP_ORI:  regs_q[rr] = a | imm;
      OP_LD, OP_ST: begin
        addr = sx16(a) + sx16(imm);
        if (!addr_ok(addr)) regs_q[StatusReg] = 16'(ST_MEMF);
        else if (op == OP_LD) regs_q[rr] = mem_q[addr][15:0];
        else begin
          mem_q[addr] = {{16{regs_q[rr][15]}}, regs_q[rr]};
          mem_set[addr] = 1'b1;
        end
      end
      OP_BEQ: if (regs_q[rr] == a) pc_q = imm + code_base_q - 16'd1;
      OP_BNE: if (regs_q[rr] != a) pc_q = imm + code_base_q - 16'd1;
      OP_J:   pc_q = imm + code_base_q - 16'd1;
      OP_JAL: begin
        regs_q[LinkReg] = pc_q;
        pc_q = imm;
      end
      default: regs_q[StatusReg] = 16'(ST_ILLEGAL);
    endcase
    pc_q = pc_q + 16'd1;
  endtask

  task automatic step_core(input func_e f, input logic [15:0] t, input logic [31:0] v,
                           output core_result_t r);
    r.print_valid = 1'b0;
    r.print_value = '0;
    case (f)
      FUNC_MEM_WR: if (t < MemWords) begin
        mem_q[t] = v;
        mem_set[t] = 1'b1;
      end
      FUNC_REG_WR: if (t < RegCount) regs_q[t] = v[15:0];
      FUNC_SET_PC: pc_q = v[15:0];
      default: if (regs_q[StatusReg] == 0) run_instr(r.print_valid, r.print_value);
    endcase
    r.status = regs_q[StatusReg][2:0];
    r.halted = regs_q[StatusReg] != 0;
    r.next_pc = pc_q;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker: every done beat pops the oldest expectation
  initial begin
    core_result_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && done_o) begin
        if (pending_results.size() == 0) report_mismatch("unexpected beat", 0, 0);
        else begin
          e = pending_results.pop_front();
          if (status_o !== e.status) report_mismatch("status", status_o, e.status);
          if (halted_o !== e.halted) report_mismatch("halted", halted_o, e.halted);
          if (print_valid_o !== e.print_valid)
            report_mismatch("print_valid", print_valid_o, e.print_valid);
          if (print_value_o !== e.print_value)
            report_mismatch("print_value", print_value_o, e.print_value);
          if (next_pc_o !== e.next_pc) report_mismatch("next_pc", next_pc_o, e.next_pc);
        end
      end
    end
  end

  task automatic send_item(func_e f, logic [15:0] t, logic [31:0] v);
    core_result_t r;
    start <= 1'b1;
    func_i <= f;
    target_i <= t;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    step_core(f, t, v, r);
    pending_results.push_back(r);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end else burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [15:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {16'($urandom), data};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== data) report_mismatch("register readback", prdata, data);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    if (addr == AddrCodeBase) code_base_q = data;
    else stack_base_q = data;
  endtask

  task automatic set_config(logic [15:0] cb, logic [15:0] sb);
    drain();
    apb_write(AddrCodeBase, cb);
    apb_write(AddrStackBase, sb);
  endtask

  function automatic logic [31:0] enc(op_e op, int rr, int rs, int rt);
    return {op, 5'(rr), 5'(rs), 5'(rt), 12'h000};
  endfunction

  // random instruction for the current pc, steered so that flow stays in memory
  function automatic logic [31:0] gen_instr();
    logic [31:0] w;
    int sel, tgt;
    logic [15:0] dest;
    w = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 3) return 32'h0;
    if (sel < 8) begin
      w[31:27] = 5'($urandom_range(OP_JAL + 1, 31));
      return w;
    end
    w[31:27] = 5'($urandom_range(0, OP_JAL));
    if ($urandom_range(0, 7) == 0) return w;
    dest = pc_q + 16'($urandom_range(1, 6));
    case (op_e'(w[31:27]))
      OP_LD, OP_ST: begin
        tgt = (stack_base_q < MemWords) ? $urandom_range(stack_base_q, MemWords - 1)
                                        : $urandom_range(0, MemWords - 1);
        w[16:1] = 16'(tgt) - regs_q[w[21:17]];
      end
      OP_BEQ, OP_BNE: w[16:1] = dest - code_base_q;
      OP_J:   w[26:11] = dest - code_base_q;
      OP_JAL: w[26:11] = dest - 16'd1;
      default: ;
    endcase
    return w;
  endfunction

  // makes sure the next execute touches no unwritten word, then sends it
  task automatic exec_next();
    logic [31:0] w;
    if (regs_q[StatusReg] == 0 && pc_q < MemWords) begin
      if (!mem_set[pc_q]) send_item(FUNC_MEM_WR, pc_q, gen_instr());
      w = mem_q[pc_q];
      if (w[31:27] == OP_LD && w != 0 && addr_ok(mem_addr(w)) && !mem_set[mem_addr(w)])
        send_item(FUNC_MEM_WR, 16'(mem_addr(w)), $urandom);
    end
    send_item(FUNC_EXEC, 16'($urandom), $urandom);
  endtask

  task automatic test_directed();
    set_config(16'hFFFF, 16'h0000);
    send_item(FUNC_REG_WR, 16'd1, 32'h0000_7FFF);
    send_item(FUNC_REG_WR, 16'd2, 32'hFFFF_8000);
    send_item(FUNC_REG_WR, 16'd3, 32'h0000_FFFF);
    send_item(FUNC_REG_WR, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(FUNC_MEM_WR, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(FUNC_MEM_WR, 16'd0, enc(OP_PRT, 2, 0, 0));
    send_item(FUNC_MEM_WR, 16'd1, enc(OP_DIV, 4, 2, 3));  // min / -1 wraps
    send_item(FUNC_MEM_WR, 16'd2, enc(OP_SRA, 5, 2, 1));  // oversized shifts
    send_item(FUNC_MEM_WR, 16'd3, enc(OP_SRL, 6, 2, 1));
    send_item(FUNC_MEM_WR, 16'd4, enc(OP_DIV, 7, 1, 0));  // divide by zero
    send_item(FUNC_MEM_WR, 16'd5, 32'h0);
    send_item(FUNC_SET_PC, 16'd0, 32'hABCD_0000);
    repeat (5) send_item(FUNC_EXEC, 16'd0, 32'd0);
    send_item(FUNC_EXEC, 16'hFFFF, 32'hFFFF_FFFF);        // halted: no effect
    send_item(FUNC_REG_WR, 16'(StatusReg), 32'd0);
    send_item(FUNC_EXEC, 16'd0, 32'd0);                   // zero word
    send_item(FUNC_REG_WR, 16'(StatusReg), 32'd0);
    send_item(FUNC_SET_PC, 16'd0, 32'h0000_FFFF);
    send_item(FUNC_EXEC, 16'd0, 32'd0);                   // fetch beyond memory
  endtask

  task automatic test_random();
    logic [15:0] cbs [5] = '{16'h0000, 16'hFFFF, 16'h0010, 16'h8000, 16'h0001};
    logic [15:0] sbs [5] = '{16'h0000, 16'h0FFF, 16'h0800, 16'hFFFF, 16'h0100};
    int sel;
    for (int phase = 0; phase < 5; phase++) begin
      set_config(phase == 4 ? 16'($urandom) : cbs[phase], sbs[phase]);
      for (int n = 0; n < 45; n++) begin
        sel = $urandom_range(0, 99);
        if (regs_q[StatusReg] != 0 && sel < 60)
          send_item(FUNC_REG_WR, 16'(StatusReg),
                    $urandom_range(0, 3) == 0 ? $urandom : 32'd0);
        else if (sel < 72) send_item(FUNC_REG_WR, 16'($urandom), $urandom);
        else if (sel < 78)
          send_item(FUNC_REG_WR, 16'($urandom_range(0, RegCount - 1)), $urandom);
        else if (sel < 82) send_item(FUNC_MEM_WR, 16'($urandom), $urandom);
        else if (sel < 85)
          send_item(FUNC_SET_PC, 16'($urandom), $urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 600));
        else exec_next();
        if (pc_q >= MemWords && $urandom_range(0, 1))
          send_item(FUNC_SET_PC, 16'($urandom), $urandom_range(0, 600));
        repeat (2) if (sel >= 50) exec_next();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0; func_i = '0; target_i = '0; value_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0;
    burst_left = 0;
    pc_q = '0; code_base_q = '0; stack_base_q = '0;
    foreach (regs_q[i]) regs_q[i] = '0;
    foreach (mem_set[i]) mem_set[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/srcs_pkg.sv
rtl/core/srcs_ram.sv
rtl/core/srcs_div.sv
rtl/core/sixteen_bit_risc_core_step_top.sv
dv/sixteen_bit_risc_core_step_top_tb.sv
